// File: src/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types and constants for the reference-counted handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package rht_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int HANDLE_W    = 32;
  localparam int COUNT_OUT_W = 16;
  localparam int OCC_OUT_W   = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic                   found;
    logic                   freed;
    logic                   dropped_full;
    logic [COUNT_OUT_W-1:0] count_after;
    logic [OCC_OUT_W-1:0]   entries_in_use;
  } rht_res_t;

endpackage

`default_nettype wire

// File: src/refcount_handle_table.sv
// ----------------------------------------------------------------------------
// refcount_handle_table
// Packed table of resource handles with saturating reference counts.
//
//   channel  dir  tdata                          tuser
//   in_      in   handle[31:0]                   opcode (0 acquire, 1 release)
//   out_     out  count_after[15:0],             found, freed, dropped_full
//                 entries_in_use[22:16]
//
// A request scans the used slots from slot 0 until it finds its handle or runs
// out; a release that removes its entry then moves the tail down one slot at a
// time through the write port. The table memory has one write and one registered
// read port. Reset clears occupancy and control state, not the table memory. A
// finished result sits in the output register, so the next request is taken
// while it waits; a stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module refcount_handle_table #(
  parameter int TABLE_DEPTH = rht_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_WIDTH = rht_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [rht_pkg::IN_TDATA_W-1:0]  in_tdata,   // handle
  input  wire logic                            in_tuser,   // opcode
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rht_pkg::OUT_TDATA_W-1:0]      out_tdata,  // count_after, entries_in_use
  output logic [rht_pkg::OUT_TUSER_W-1:0]      out_tuser   // found, freed, dropped_full
);
  import rht_pkg::*;

  logic                   ctrl_ready;
  logic                   res_vld;
  logic                   res_rdy;
  rht_res_t               res;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  assign in_tready  = ctrl_ready;
  assign res_rdy    = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  rht_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_tvalid && ctrl_ready),
    .start_op     (in_tuser),
    .start_handle (in_tdata),
    .ready        (ctrl_ready),
    .res_vld      (res_vld),
    .res_rdy      (res_rdy),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_rdy) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && res_rdy) begin
      out_data_r <= {1'b0, res.entries_in_use, res.count_after};
      out_user_r <= {res.dropped_full, res.freed, res.found};
    end
  end

endmodule

`default_nettype wire

// File: src/rht_ctrl.sv
// ----------------------------------------------------------------------------
// rht_ctrl
// Sequencer and table memory: scans entries through one compare unit, updates
// the count, appends new handles and shifts the tail down on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module rht_ctrl #(
  parameter int TABLE_DEPTH = rht_pkg::DEF_TABLE_DEPTH,
  parameter int COUNT_WIDTH = rht_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          start_op,
  input  wire logic [rht_pkg::HANDLE_W-1:0]  start_handle,
  output logic                               ready,
  output logic                               res_vld,
  input  wire logic                          res_rdy,
  output rht_pkg::rht_res_t                  res
);
  import rht_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = HANDLE_W + COUNT_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_SHIFT,
    S_MISS,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic                   op_r;
  logic [HANDLE_W-1:0]    hdl_r;
  logic [OCC_W-1:0]       occ_r;
  logic [OCC_W-1:0]       scan_idx_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [IDX_W-1:0]       slot_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;
  logic                   found_r;
  logic                   freed_r;
  logic                   dropped_r;

  logic [ENT_W-1:0]       mem_r [TABLE_DEPTH];
  logic [ENT_W-1:0]       rd_data_r;

  logic [IDX_W-1:0]       rd_addr;
  logic                   issue;
  logic [HANDLE_W-1:0]    rd_hdl;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic                   match;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic                   cnt_low;
  logic                   full;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [ENT_W-1:0]       wdata;
  logic [COUNT_WIDTH+COUNT_OUT_W-1:0] cnt_wide;
  logic [OCC_W+OCC_OUT_W-1:0]         occ_wide;

  assign rd_addr  = scan_idx_r[IDX_W-1:0];
  assign issue    = (scan_idx_r < occ_r);
  assign rd_hdl   = rd_data_r[ENT_W-1:COUNT_WIDTH];
  assign rd_cnt   = rd_data_r[COUNT_WIDTH-1:0];
  assign match    = cmp_vld_r && (rd_hdl == hdl_r);
  assign cnt_inc  = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;
  assign cnt_low  = (cnt_r[COUNT_WIDTH-1:1] == '0);
  assign full     = (occ_r == OCC_W'(TABLE_DEPTH));

  assign ready    = (state_r == S_IDLE);
  assign res_vld  = (state_r == S_DONE);
  assign cnt_wide = {{COUNT_OUT_W{1'b0}}, res_cnt_r};
  assign occ_wide = {{OCC_OUT_W{1'b0}}, occ_r};

  always_comb begin
    res.found          = found_r;
    res.freed          = freed_r;
    res.dropped_full   = dropped_r;
    res.count_after    = cnt_wide[COUNT_OUT_W-1:0];
    res.entries_in_use = occ_wide[OCC_OUT_W-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot_r;
    wdata = {hdl_r, cnt_inc};
    unique case (state_r)
      S_HIT: begin
        if (op_r == OP_ACQUIRE) begin
          we = 1'b1;
        end else if (!cnt_low) begin
          we    = 1'b1;
          wdata = {hdl_r, cnt_dec};
        end
      end
      S_SHIFT: begin
        we    = cmp_vld_r;
        waddr = cmp_idx_r - 1'b1;
        wdata = rd_data_r;
      end
      S_MISS: begin
        we    = (op_r == OP_ACQUIRE) && !full;
        waddr = occ_r[IDX_W-1:0];
        wdata = {hdl_r, COUNT_WIDTH'(1)};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r       <= start_op;
            hdl_r      <= start_handle;
            scan_idx_r <= '0;
            cmp_vld_r  <= 1'b0;
            found_r    <= 1'b0;
            freed_r    <= 1'b0;
            dropped_r  <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            slot_r    <= cmp_idx_r;
            cnt_r     <= rd_cnt;
            cmp_vld_r <= 1'b0;
            state_r   <= S_HIT;
          end else if (issue) begin
            cmp_vld_r  <= 1'b1;
            cmp_idx_r  <= scan_idx_r[IDX_W-1:0];
            scan_idx_r <= scan_idx_r + 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
            state_r   <= S_MISS;
          end
        end
        S_HIT: begin
          found_r <= 1'b1;
          if (op_r == OP_ACQUIRE) begin
            res_cnt_r <= cnt_inc;
            state_r   <= S_DONE;
          end else if (cnt_low) begin
            freed_r    <= 1'b1;
            res_cnt_r  <= '0;
            scan_idx_r <= OCC_W'(slot_r) + 1'b1;
            state_r    <= S_SHIFT;
          end else begin
            res_cnt_r <= cnt_dec;
            state_r   <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (issue) begin
            cmp_vld_r  <= 1'b1;
            cmp_idx_r  <= scan_idx_r[IDX_W-1:0];
            scan_idx_r <= scan_idx_r + 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
            occ_r     <= occ_r - 1'b1;
            state_r   <= S_DONE;
          end
        end
        S_MISS: begin
          res_cnt_r <= '0;
          if (op_r == OP_ACQUIRE) begin
            if (full) begin
              dropped_r <= 1'b1;
            end else begin
              occ_r     <= occ_r + 1'b1;
              res_cnt_r <= COUNT_WIDTH'(1);
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_rdy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_refcount_handle_table.sv
// ----------------------------------------------------------------------------
// tb_refcount_handle_table
// Self-checking bench for the reference-counted handle table. A queue of
// requests feeds a stream driver; each accepted transfer runs through a local
// model of the table, and the monitor checks every reply against the oldest
// prediction. Stimulus covers handle extremes, misses, removal with tail
// shift, repeated hits back to back, a full table and random grow/drain
// traffic, with random gaps on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_refcount_handle_table;
  import rht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TDEPTH     = DEF_TABLE_DEPTH;
  localparam int CNT_W      = DEF_COUNT_WIDTH;
  localparam int POOL_N     = 80;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic        op;
    logic [31:0] handle;
    int          tx_gap;
    int          rx_gap;
  } req_t;

  typedef struct {
    rht_res_t res;
    int       rx_gap;
  } reply_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  req_t   request_q[$];
  reply_t due_replies[$];

  logic [31:0]      tbl_handle [TDEPTH];
  logic [CNT_W-1:0] tbl_count  [TDEPTH];
  int               tbl_used = 0;

  int tx_wait = 0;
  bit tx_armed = 0;
  int rx_wait = 0;
  bit rx_armed = 0;
  int n_accepted = 0;
  int fail_count = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit calm = 0;

  refcount_handle_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("refcount_handle_table verification failed");
    $finish;
  end

  function automatic rht_res_t track_request(logic op, logic [31:0] h);
    rht_res_t r;
    int slot;
    r = '0;
    slot = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (slot < 0 && tbl_handle[i] == h) slot = i;
    end
    r.found = (slot >= 0);
    if (op == OP_ACQUIRE) begin
      if (slot >= 0) begin
        if (tbl_count[slot] != '1) tbl_count[slot] = tbl_count[slot] + 1'b1;
        r.count_after = tbl_count[slot];
      end else if (tbl_used >= TDEPTH) begin
        r.dropped_full = 1'b1;
      end else begin
        tbl_handle[tbl_used] = h;
        tbl_count[tbl_used]  = CNT_W'(1);
        tbl_used++;
        r.count_after = COUNT_OUT_W'(1);
      end
    end else if (slot >= 0) begin
      if (tbl_count[slot] <= 1) begin
        r.freed = 1'b1;
        for (int i = slot; i + 1 < tbl_used; i++) begin
          tbl_handle[i] = tbl_handle[i + 1];
          tbl_count[i]  = tbl_count[i + 1];
        end
        tbl_used--;
      end else begin
        tbl_count[slot] = tbl_count[slot] - 1'b1;
        r.count_after = tbl_count[slot];
      end
    end
    r.entries_in_use = tbl_used[OCC_OUT_W-1:0];
    return r;
  endfunction

  function automatic string show(rht_res_t r);
    return $sformatf("found=%0d freed=%0d dropped=%0d count=%0d used=%0d",
                     r.found, r.freed, r.dropped_full, r.count_after, r.entries_in_use);
  endfunction

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic queue_req(logic op, logic [31:0] h, bit quick);
    req_t q;
    q.op     = op;
    q.handle = h;
    q.tx_gap = quick ? 0 : pick_gap();
    q.rx_gap = quick ? 0 : pick_gap();
    request_q.push_back(q);
  endtask

  // driver: accept and predict at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    reply_t due;
    if (rst_n && in_tvalid && in_tready) begin
      due.res    = track_request(request_q[0].op, request_q[0].handle);
      due.rx_gap = request_q[0].rx_gap;
      due_replies.push_back(due);
      request_q.pop_front();
      n_accepted++;
      if (request_q.size() != 0) begin
        tx_wait  = request_q[0].tx_gap;
        tx_armed = 1;
      end else begin
        tx_armed = 0;
      end
    end else if (rst_n && !tx_armed && request_q.size() != 0) begin
      tx_wait  = request_q[0].tx_gap;
      tx_armed = 1;
    end else if (tx_wait != 0) begin
      tx_wait--;
    end
  end

  always @(negedge clk) begin
    in_tvalid <= tx_armed && tx_wait == 0;
    if (tx_armed) begin
      in_tdata <= request_q[0].handle;
      in_tuser <= request_q[0].op;
    end
  end

  // monitor: check each reply transfer against the oldest prediction
  always @(posedge clk) begin
    rht_res_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.found          = out_tuser[0];
      seen.freed          = out_tuser[1];
      seen.dropped_full   = out_tuser[2];
      seen.count_after    = out_tdata[COUNT_OUT_W-1:0];
      seen.entries_in_use = out_tdata[COUNT_OUT_W +: OCC_OUT_W];
      if (due_replies.size() == 0) begin
        if (fail_count < 10) $display("unexpected reply: %s", show(seen));
        fail_count++;
      end else begin
        if (seen !== due_replies[0].res) begin
          if (fail_count < 10)
            $display("reply mismatch at %0t: expected %s, got %s", $realtime,
                     show(due_replies[0].res), show(seen));
          fail_count++;
        end
        due_replies.pop_front();
      end
      if (due_replies.size() != 0) begin
        rx_wait  = due_replies[0].rx_gap;
        rx_armed = 1;
      end else begin
        rx_armed = 0;
      end
    end else if (rst_n && !rx_armed && due_replies.size() != 0) begin
      rx_wait  = due_replies[0].rx_gap;
      rx_armed = 1;
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
  end

  always @(posedge clk) begin
    if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_tready <= (!rx_armed || rx_wait == 0) && hold_left == 0;
  end

  initial begin
    logic [31:0] pool [POOL_N];
    logic [31:0] held [$];
    logic [31:0] h;
    int k;
    bit grow;

    grow = 0;

    // directed: handle extremes, hits, misses, removal from head and tail
    queue_req(OP_ACQUIRE, 32'h0000_0000, 0);
    queue_req(OP_ACQUIRE, 32'hFFFF_FFFF, 0);
    queue_req(OP_ACQUIRE, 32'h0000_0000, 0);
    queue_req(OP_RELEASE, 32'h1234_5678, 0);
    queue_req(OP_RELEASE, 32'hFFFF_FFFF, 0);
    queue_req(OP_RELEASE, 32'h0000_0000, 0);
    queue_req(OP_ACQUIRE, 32'h8000_0000, 0);
    queue_req(OP_ACQUIRE, 32'h0000_0001, 0);
    queue_req(OP_RELEASE, 32'h0000_0000, 0);
    queue_req(OP_RELEASE, 32'h0000_0001, 0);
    queue_req(OP_RELEASE, 32'h8000_0000, 0);
    queue_req(OP_RELEASE, 32'h0000_0000, 0);

    // raise one count back to back
    for (int i = 0; i < 20; i++) queue_req(OP_ACQUIRE, 32'h5A5A_5A5A, 1);
    queue_req(OP_RELEASE, 32'h5A5A_5A5A, 0);
    queue_req(OP_ACQUIRE, 32'h5A5A_5A5A, 0);

    // fill the table past capacity, then release the first TDEPTH-1 handles once each in random order
    for (int i = 0; i < TDEPTH + 6; i++) begin
      h = $urandom;
      queue_req(OP_ACQUIRE, h, 0);
      if (i < TDEPTH - 1) held.push_back(h);
    end
    queue_req(OP_ACQUIRE, held[5], 0);
    queue_req(OP_RELEASE, 32'hDEAD_BEEF, 0);
    while (held.size() != 0) begin
      k = $urandom_range(0, held.size() - 1);
      queue_req(OP_RELEASE, held[k], 0);
      held.delete(k);
    end

    for (int i = 0; i < POOL_N; i++) pool[i] = $urandom;
    for (int i = 0; i < 880; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i % 150 == 0) grow = !grow;
      k = $urandom_range(0, 99);
      if (k < 6)
        queue_req(logic'($urandom_range(0, 1)), $urandom, 0);
      else
        queue_req((k < (grow ? 72 : 40)) ? OP_ACQUIRE : OP_RELEASE,
                  pool[$urandom_range(0, POOL_N - 1)], 0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || due_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("refcount_handle_table verification clean");
    end else begin
      $display("refcount_handle_table verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
